@@ rtl/assert_macros.svh @@
// assertion macros included by tile_row_flipper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TLRF_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TLRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/tlrf_pkg.sv @@
// types, constants and the row mirror function for the tile row flipper
package tlrf_pkg;

  localparam int ROWS_PER_TILE = 8;
  localparam int ROW_W         = 32;
  localparam int PIX_W         = 4;
  localparam int NUM_PIX       = ROW_W / PIX_W;
  localparam int IDX_W         = $clog2(ROWS_PER_TILE);

  // tuser bit positions on the input side
  localparam int TUSER_HFLIP = 0;
  localparam int TUSER_VFLIP = 1;
  localparam int TUSER_W     = 2;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [IDX_W-1:0] row_idx_t;

  localparam row_idx_t LAST_IDX  = row_idx_t'(ROWS_PER_TILE - 1);
  localparam row_idx_t FIRST_RD  = row_idx_t'(ROWS_PER_TILE - 2);

  // reverse the pixel order of a row
  function automatic row_t mirror_row(row_t w);
    row_t r;
    r = '0;
    for (int k = 0; k < NUM_PIX; k++) begin
      r[PIX_W*(NUM_PIX-1-k) +: PIX_W] = w[PIX_W*k +: PIX_W];
    end
    return r;
  endfunction

endpackage

@@ rtl/tlrf_ram.sv @@
// generic single write port, single read port ram with registered read
module tlrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/tile_row_flipper.sv @@
// top level of the tile row flipper: 4bpp tile row mirror and row order reversal
//
// channel | dir | tdata              | tuser / tlast
// --------+-----+--------------------+-------------------------------------
// in_     | in  | [31:0] row_pixels  | tuser[0] flip_horizontal,
//         |     |                    | tuser[1] flip_vertical
// out_    | out | [31:0] row_out     | tlast = last_row
//
// a tile without vertical flip passes one beat per cycle while the output is
// not stalled, each row going out through the output register
// a vertically flipped tile takes its rows into the row buffer ram at one beat
// per cycle; the eighth row goes out at once and the other seven are read back
// from the registered ram read port in reverse order, one per cycle while the
// output takes them, with input held off until the last of them is loaded; the
// single ram read port paces the burst
// reset (rst_n low, synchronous) clears the state, row counter, flags, read pointer
// and handshake state only; the buffer is never cleared since every row is written before read
// output stalls back up through in_tready; the burst pauses with a read pending
module tile_row_flipper (
  input  logic                              clk,
  input  logic                              rst_n,
  // input row beats
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tlrf_pkg::ROW_W-1:0]        in_tdata,   // [31:0] row_pixels
  input  logic [tlrf_pkg::TUSER_W-1:0]      in_tuser,   // [0] flip_horizontal, [1] flip_vertical
  // output row beats
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tlrf_pkg::ROW_W-1:0]        out_tdata,  // [31:0] row_out
  output logic                              out_tlast   // last_row
);

  `include "assert_macros.svh"

  // state codes
  localparam logic ST_PASS  = 1'b0;  // taking input beats
  localparam logic ST_BURST = 1'b1;  // replaying buffered rows in reverse

  logic                state_r, state_nxt;
  tlrf_pkg::row_idx_t  row_cnt_r, row_cnt_nxt;
  logic                held_h_r, held_h_nxt;
  logic                held_v_r, held_v_nxt;
  tlrf_pkg::row_idx_t  rd_idx_r, rd_idx_nxt;
  logic                reads_left_r, reads_left_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic                pend_last_r, pend_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  tlrf_pkg::row_t      out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;

  logic                out_free;
  logic                in_acc;
  logic                first_row;
  logic                last_row;
  logic                eff_h;
  logic                eff_v;
  tlrf_pkg::row_t      row_flip;
  logic                wr_en;
  logic                rd_en;
  logic                load_rd;
  tlrf_pkg::row_t      rd_data;

  // row buffer
  tlrf_ram #(
    .WIDTH (tlrf_pkg::ROW_W),
    .DEPTH (tlrf_pkg::ROWS_PER_TILE)
  ) u_row_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (row_cnt_r),
    .wr_data (row_flip),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  // handshake and flag selection
  always_comb begin
    out_free  = !out_valid_r || out_tready;
    in_tready = (state_r == ST_PASS) && out_free;
    in_acc    = in_tvalid && in_tready;
    first_row = (row_cnt_r == '0);
    last_row  = (row_cnt_r == tlrf_pkg::LAST_IDX);
    // flags come straight from the beat on the first row, latched afterwards
    eff_h     = first_row ? in_tuser[tlrf_pkg::TUSER_HFLIP] : held_h_r;
    eff_v     = first_row ? in_tuser[tlrf_pkg::TUSER_VFLIP] : held_v_r;
    row_flip  = eff_h ? tlrf_pkg::mirror_row(in_tdata) : in_tdata;
    // the final row of a flipped tile goes out directly, the rest are stored
    wr_en     = in_acc && eff_v && !last_row;
    // read data sits in the ram output until the output register takes it
    load_rd   = (state_r == ST_BURST) && rd_pend_r && out_free;
    rd_en     = (state_r == ST_BURST) && reads_left_r && (!rd_pend_r || load_rd);
  end

  // next state
  always_comb begin
    state_nxt      = state_r;
    row_cnt_nxt    = row_cnt_r;
    held_h_nxt     = held_h_r;
    held_v_nxt     = held_v_r;
    rd_idx_nxt     = rd_idx_r;
    reads_left_nxt = reads_left_r;
    rd_pend_nxt    = rd_pend_r;
    pend_last_nxt  = pend_last_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      row_cnt_nxt = last_row ? '0 : row_cnt_r + 1'b1;
      if (first_row) begin
        held_h_nxt = in_tuser[tlrf_pkg::TUSER_HFLIP];
        held_v_nxt = in_tuser[tlrf_pkg::TUSER_VFLIP];
      end
      if (!eff_v || last_row) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = row_flip;
        out_last_nxt  = last_row && !eff_v;
      end
      if (eff_v && last_row) begin
        state_nxt      = ST_BURST;
        rd_idx_nxt     = tlrf_pkg::FIRST_RD;
        reads_left_nxt = 1'b1;
      end
    end

    if (load_rd) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rd_data;
      out_last_nxt  = pend_last_r;
      rd_pend_nxt   = 1'b0;
      if (pend_last_r) begin
        state_nxt = ST_PASS;
      end
    end

    if (rd_en) begin
      rd_pend_nxt   = 1'b1;
      pend_last_nxt = (rd_idx_r == '0);
      if (rd_idx_r == '0) begin
        reads_left_nxt = 1'b0;
      end else begin
        rd_idx_nxt = rd_idx_r - 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_PASS;
      row_cnt_r    <= '0;
      held_h_r     <= 1'b0;
      held_v_r     <= 1'b0;
      rd_idx_r     <= '0;
      reads_left_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      pend_last_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_cnt_r    <= row_cnt_nxt;
      held_h_r     <= held_h_nxt;
      held_v_r     <= held_v_nxt;
      rd_idx_r     <= rd_idx_nxt;
      reads_left_r <= reads_left_nxt;
      rd_pend_r    <= rd_pend_nxt;
      pend_last_r  <= pend_last_nxt;
      out_valid_r  <= out_valid_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  `TLRF_ASSERT_ALWAYS(a_no_wr_during_rd, clk, rst_n, !(wr_en && rd_en),
                      "row buffer written and read in the same cycle")
  `TLRF_ASSERT_IMPL(a_last_at_tile_end, clk, rst_n, out_tvalid && out_tlast,
                    row_cnt_r == '0, "tile end shown while the row counter is mid tile")
  `TLRF_ASSERT_IMPL(a_pend_only_in_burst, clk, rst_n, rd_pend_r,
                    state_r == ST_BURST, "buffered row pending outside the burst")

endmodule
